// File: hdl/udiv64_pkg.sv
// Shared types and constants for the 64-bit unsigned divider.
package udiv64_pkg;

  localparam int DATA_W = 64;
  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

endpackage

// File: hdl/udiv64_ctrl.sv
// Controller state machine that sequences load, iteration and result hand-off.
module udiv64_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output udiv64_pkg::dp_cmd_t  cmd
);

  udiv64_pkg::state_t                state_r;
  udiv64_pkg::state_t                state_nxt;
  logic [udiv64_pkg::CNT_W-1:0]      cnt_r;
  logic [udiv64_pkg::CNT_W-1:0]      cnt_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic                              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      udiv64_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = udiv64_pkg::ST_RUN;
        end
      end
      udiv64_pkg::ST_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = udiv64_pkg::ST_DONE;
        end
      end
      udiv64_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = udiv64_pkg::ST_IDLE;
        end
      end
      default: state_nxt = udiv64_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      udiv64_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      udiv64_pkg::ST_RUN: begin
        cmd.step = 1'b1;
      end
      udiv64_pkg::ST_DONE: begin
        cmd.publish = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = udiv64_pkg::LAST_STEP;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udiv64_pkg::ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/udiv64_dp.sv
// Datapath with the shared restoring-division step and the result register.
module udiv64_dp (
  input  logic                            clk,
  input  udiv64_pkg::dp_cmd_t             cmd,
  input  logic [udiv64_pkg::DATA_W-1:0]   in_dividend,
  input  logic [udiv64_pkg::DATA_W-1:0]   in_divisor,
  output logic [udiv64_pkg::DATA_W-1:0]   out_quotient,
  output logic                            out_divide_by_zero
);

  logic [udiv64_pkg::DATA_W-1:0] nq_r;
  logic [udiv64_pkg::DATA_W-1:0] nq_nxt;
  logic [udiv64_pkg::DATA_W-1:0] rem_r;
  logic [udiv64_pkg::DATA_W-1:0] rem_nxt;
  logic [udiv64_pkg::DATA_W-1:0] dvs_r;
  logic                          zero_r;
  logic [udiv64_pkg::DATA_W-1:0] quot_r;
  logic                          dbz_r;
  logic [udiv64_pkg::DATA_W:0]   shifted;
  logic [udiv64_pkg::DATA_W:0]   diff;
  logic                          fits;

  // The partial remainder is 65 bits wide after the shift; the top bit of the
  // difference is the borrow that says whether the divisor fits.
  assign shifted = {rem_r, nq_r[udiv64_pkg::DATA_W-1]};
  assign diff = shifted - {1'b0, dvs_r};
  assign fits = !diff[udiv64_pkg::DATA_W];

  always_comb begin
    nq_nxt = {nq_r[udiv64_pkg::DATA_W-2:0], fits};
    rem_nxt = fits ? diff[udiv64_pkg::DATA_W-1:0] : shifted[udiv64_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nq_r <= in_dividend;
      rem_r <= '0;
      dvs_r <= in_divisor;
      zero_r <= (in_divisor == '0);
    end else if (cmd.step) begin
      nq_r <= nq_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.publish) begin
      quot_r <= zero_r ? '0 : nq_r;
      dbz_r <= zero_r;
    end
  end

  assign out_quotient = quot_r;
  assign out_divide_by_zero = dbz_r;

endmodule

// File: hdl/unsigned_divider_64_core.sv
// Top level of the 64-bit unsigned restoring divider.
// A division goes from the accepted input beat to the result beat in a load
// step, 64 iterations of a single shared subtract-and-shift step producing
// one quotient bit each, and a move of the quotient into the output register
// once any earlier result there has been taken. One item is in flight at a
// time; a new input beat is taken as soon as the finished quotient sits in
// the output register, even if that result has not been taken yet. A zero
// divisor gives a zero quotient with divide_by_zero set.
module unsigned_divider_64_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [udiv64_pkg::DATA_W-1:0]   in_dividend,
  input  logic [udiv64_pkg::DATA_W-1:0]   in_divisor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [udiv64_pkg::DATA_W-1:0]   out_quotient,
  output logic                            out_divide_by_zero
);

  udiv64_pkg::dp_cmd_t cmd;

  udiv64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  udiv64_dp u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_quotient       (out_quotient),
    .out_divide_by_zero (out_divide_by_zero)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a division is in progress");

  a_dbz_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_quotient == '0))
    else $error("divide by zero result carries a nonzero quotient");

  a_no_load_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.step || cmd.publish)))
    else $error("datapath commands overlap");
`endif

endmodule

// File: dv/udiv64_checker.sv
// Checker for the 64-bit divider: predicts each quotient beat and compares it with the block.
module udiv64_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [udiv64_pkg::DATA_W-1:0] in_dividend,
  input  logic [udiv64_pkg::DATA_W-1:0] in_divisor,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [udiv64_pkg::DATA_W-1:0] out_quotient,
  input  logic                          out_divide_by_zero,
  output int                            fail_count,
  output int                            pending,
  output int                            checked_count,
  output int                            zero_div_count
);

  localparam int W = udiv64_pkg::DATA_W;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         divide_by_zero;
  } quot_beat_t;

  quot_beat_t awaited_quotients[$];

  initial begin
    fail_count = 0;
    pending = 0;
    checked_count = 0;
    zero_div_count = 0;
  end

  function automatic quot_beat_t restoring_quotient(input logic [W-1:0] num,
                                                    input logic [W-1:0] den);
    quot_beat_t res;
    logic [W:0] rem;
    logic [W-1:0] bits;
    res.divide_by_zero = (den == '0);
    res.quotient = '0;
    rem = '0;
    bits = num;
    if (den != '0 && num != '0) begin
      for (int i = 0; i < W; i++) begin
        rem = {rem[W-1:0], bits[W-1]};
        bits = bits << 1;
        res.quotient = res.quotient << 1;
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          res.quotient[0] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    quot_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_quotients.size() == 0) begin
          $display("%0t: result beat with no division outstanding: quotient %h, flag %b",
                   $time, out_quotient, out_divide_by_zero);
          fail_count++;
        end else begin
          want = awaited_quotients.pop_front();
          checked_count++;
          if (out_quotient !== want.quotient) begin
            $display("%0t: quotient mismatch: expected %h, actual %h",
                     $time, want.quotient, out_quotient);
            fail_count++;
          end
          if (out_divide_by_zero !== want.divide_by_zero) begin
            $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                     $time, want.divide_by_zero, out_divide_by_zero);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = restoring_quotient(in_dividend, in_divisor);
        if (want.divide_by_zero) zero_div_count++;
        awaited_quotients.push_back(want);
      end
      pending = awaited_quotients.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the divider testbench: clock, reset, stimulus, stalls and the verdict.
module testbench;

  localparam int W = udiv64_pkg::DATA_W;
  localparam int RANDOM_ITEMS = 1530;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_quotient;
  logic         out_divide_by_zero;

  int fail_count;
  int pending;
  int checked_count;
  int zero_div_count;
  int sent_count = 0;
  int quiet_cycles = 0;
  logic calm = 1'b0;

  always #5 clk = ~clk;

  unsigned_divider_64_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_dividend(in_dividend),
    .in_divisor(in_divisor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_quotient(out_quotient),
    .out_divide_by_zero(out_divide_by_zero)
  );

  udiv64_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_dividend(in_dividend),
    .in_divisor(in_divisor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_quotient(out_quotient),
    .out_divide_by_zero(out_divide_by_zero),
    .fail_count(fail_count),
    .pending(pending),
    .checked_count(checked_count),
    .zero_div_count(zero_div_count)
  );

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
        $display("unsigned_divider_64_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [W-1:0] rand_narrow();
    return rand_word() >> $urandom_range(0, W - 1);
  endfunction

  task automatic send_beat(input logic [W-1:0] num, input logic [W-1:0] den);
    if (!calm && $urandom_range(99) < 30) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_dividend <= num;
    in_divisor <= den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_beat();
    logic [W-1:0] num;
    logic [W-1:0] den;
    num = rand_word();
    den = rand_word();
    case ($urandom_range(0, 9)) inside
      0: ;
      1: den = '0;
      2: den[W-1] = 1'b1;
      3: den = den >> $urandom_range(W / 2, W - 1);
      4: den = num + W'($urandom_range(0, 2)) - W'(1);
      5: num = '0;
      6, 7: begin
        num = rand_narrow();
        den = rand_narrow();
      end
      8: num = num >> $urandom_range(8, W - 1);
      default: begin
        num = W'(1) << $urandom_range(0, W - 1);
        den = W'(1) << $urandom_range(0, W - 1);
      end
    endcase
    send_beat(num, den);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(64'h0, 64'h0);
    send_beat(64'h0, 64'h1);
    send_beat(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_beat(64'h0000_0000_0000_007B, 64'h0);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h2);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(64'h1, 64'h1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
    send_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_beat(64'h8000_0000_0000_0000, 64'h1);
    send_beat(64'hC000_0000_0000_0000, 64'h8000_0000_0000_0001);
    send_beat(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(64'h0000_0000_0000_0005, 64'h0000_0000_0000_0003);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    send_beat(64'h1234_5678_9ABC_DEF0, 64'h0000_0000_0000_0007);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1100) drain_results();
      send_random_beat();
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d divisions with random gaps and result stalls; %0d had a zero divisor.",
             sent_count, zero_div_count);
    $display("Checked %0d result beats against the predicted quotient and flag.",
             checked_count);
    if (fail_count == 0) begin
      $display("unsigned_divider_64_core verification clean");
    end else begin
      $display("unsigned_divider_64_core verification failed");
    end
    $finish;
  end

endmodule
